>>> rtl/core/rsc_pkg.sv
`default_nettype none

package rsc_pkg;

    localparam int WordW  = 16;
    localparam int LinesW = 16;
    localparam int RunW   = 15;

    typedef enum logic [1:0] {
        MODE_PASS    = 2'd0,
        MODE_555_565 = 2'd1,
        MODE_565_555 = 2'd2,
        MODE_UNUSED  = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        KIND_TRANSPARENT = 3'd0,
        KIND_COLOUR      = 3'd1,
        KIND_PIXEL       = 3'd2,
        KIND_LINE_END    = 3'd3,
        KIND_TRAILER     = 3'd4
    } t_kind;

    typedef enum logic {
        CFG_MODE  = 1'b0,
        CFG_LINES = 1'b1
    } t_cfg_index;

    localparam logic [WordW-1:0] Grey565 = 16'h0821;
    localparam logic [WordW-1:0] Grey555 = 16'h0421;

endpackage

`default_nettype wire

>>> rtl/core/rsc_pix_conv.sv
`default_nettype none

module rsc_pix_conv (
    input  wire rsc_pkg::t_mode            i_mode,
    input  wire logic [rsc_pkg::WordW-1:0] i_pixel,
    output logic      [rsc_pkg::WordW-1:0] o_pixel
);
    import rsc_pkg::*;

    logic [WordW-1:0] to_565;
    logic [WordW-1:0] to_555;
    logic             src_555_nz;
    logic             src_565_nz;

    // Bit 15 of a 555 word carries no colour and is dropped.
    assign src_555_nz = |i_pixel[14:0];
    assign src_565_nz = |i_pixel;

    always_comb begin
        to_565 = {i_pixel[14:10], i_pixel[9:5], 1'b0, i_pixel[4:0]};
        if (to_565 == '0 && src_555_nz) begin
            to_565 = Grey565;
        end
        // The low green bit is lost, so a color made only of it turns grey.
        to_555 = {1'b0, i_pixel[15:11], i_pixel[10:6], i_pixel[4:0]};
        if (to_555 == '0 && src_565_nz) begin
            to_555 = Grey555;
        end
    end

    always_comb begin
        case (i_mode)
            MODE_555_565: o_pixel = to_565;
            MODE_565_555: o_pixel = to_555;
            default:      o_pixel = i_pixel;
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/core/rle_sprite_colour_format_convert.sv
`default_nettype none

// Run-length sprite stream color converter.
// The input channel (i_valid, o_stall, i_stream_word) takes one word of the
// sprite stream; the output channel (o_valid, i_stall, o_out_word,
// o_word_kind, o_image_end) gives exactly one word for each word taken.
// Pixel words inside a color run are converted between 555 and 565 as
// the mode register selects; tags and line ends pass unchanged. After the
// programmed number of line ends the next word is the trailer, flagged with
// o_image_end, and the line and run counters rearm for the next image.
// An accepted word is loaded into the input register and then into the
// result register, which drives o_valid. Throughput is one word per cycle
// while the receiver does not stall; the run and line counters are updated
// in the same cycle the word moves to the result stage.
// Reset empties both stages, clears the counters, sets the mode to pass
// through and the line count to one. When the receiver stalls, the result
// holds; the input register fills and then o_stall rises toward the sender.
// Configuration writes are taken at any edge with i_cfg_we high and act on
// the next word processed.
module rle_sprite_colour_format_convert (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire rsc_pkg::t_cfg_index        i_cfg_index,
    input  wire logic [rsc_pkg::WordW-1:0]  i_cfg_data,
    input  wire logic                       i_valid,
    output logic                            o_stall,
    input  wire logic [rsc_pkg::WordW-1:0]  i_stream_word,
    output logic                            o_valid,
    input  wire logic                       i_stall,
    output logic      [rsc_pkg::WordW-1:0]  o_out_word,
    output logic      [2:0]                 o_word_kind,
    output logic                            o_image_end
);
    import rsc_pkg::*;

    t_mode             r_mode;
    logic [LinesW-1:0] r_line_count;
    logic [RunW-1:0]   r_pixels_left;
    logic [RunW-1:0]   n_pixels_left;
    logic [LinesW-1:0] r_lines_done;
    logic [LinesW-1:0] n_lines_done;

    logic              r_in_valid;
    logic [WordW-1:0]  r_in_word;
    logic              r_out_valid;
    logic [WordW-1:0]  r_out_word;
    t_kind             r_out_kind;
    logic              r_out_end;

    logic              out_adv;
    logic              step;
    logic [WordW-1:0]  conv_word;
    logic [WordW-1:0]  n_word;
    t_kind             n_kind;
    logic              n_end;

    assign out_adv = !r_out_valid || !i_stall;
    assign step    = r_in_valid && out_adv;
    assign o_stall = r_in_valid && !out_adv;

    rsc_pix_conv u_pix_conv (
        .i_mode  (r_mode),
        .i_pixel (r_in_word),
        .o_pixel (conv_word)
    );

    always_comb begin
        n_word        = r_in_word;
        n_kind        = KIND_TRANSPARENT;
        n_end         = 1'b0;
        n_pixels_left = r_pixels_left;
        n_lines_done  = r_lines_done;
        if (r_pixels_left != '0) begin
            n_word        = conv_word;
            n_kind        = KIND_PIXEL;
            n_pixels_left = r_pixels_left - RunW'(1);
        end else if (r_lines_done >= r_line_count) begin
            n_kind       = KIND_TRAILER;
            n_end        = 1'b1;
            n_lines_done = '0;
        end else if (r_in_word == '0) begin
            n_kind       = KIND_LINE_END;
            n_lines_done = r_lines_done + LinesW'(1);
        end else if (r_in_word[0]) begin
            n_kind        = KIND_COLOUR;
            n_pixels_left = r_in_word[WordW-1:1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_PASS;
            r_line_count <= LinesW'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MODE:  r_mode       <= t_mode'(i_cfg_data[1:0]);
                CFG_LINES: r_line_count <= i_cfg_data[LinesW-1:0];
                default:   r_mode       <= r_mode;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_pixels_left <= '0;
            r_lines_done  <= '0;
        end else begin
            if (!o_stall) begin
                r_in_valid <= i_valid;
            end
            if (out_adv) begin
                r_out_valid <= r_in_valid;
            end
            if (step) begin
                r_pixels_left <= n_pixels_left;
                r_lines_done  <= n_lines_done;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_in_word <= i_stream_word;
        end
        if (step) begin
            r_out_word <= n_word;
            r_out_kind <= n_kind;
            r_out_end  <= n_end;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_out_word  = r_out_word;
    assign o_word_kind = r_out_kind;
    assign o_image_end = r_out_end;

endmodule

`default_nettype wire
